// ===== rtl/secded_pkg.sv =====
package secded_pkg;

  localparam int ADDR_W     = 14;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 6;
  localparam int STATUS_W   = 3;
  localparam int ADDR_SPACE = 16384;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FLIP  = 2'd2,
    OP_BURST = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEAN         = 3'd0,
    ST_CORRECTED     = 3'd1,
    ST_UNCORRECTABLE = 3'd2,
    ST_UNDETECTED    = 3'd3,
    ST_REJECTED      = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic load;
    logic rd_en;
    logic dec_en;
    logic upd_en;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } ctrl_stat_t;

endpackage

// ===== rtl/secded_if.sv =====
interface secded_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic [secded_pkg::ADDR_W-1:0]    address;
  logic [secded_pkg::WORD_W-1:0]    write_data;
  logic [secded_pkg::POS_W-1:0]     bit_position;
  logic [secded_pkg::POS_W-1:0]     flip_span;

  modport source (output valid, operation, address, write_data, bit_position, flip_span,
                  input ready);
  modport sink (input valid, operation, address, write_data, bit_position, flip_span,
                output ready);
endinterface

interface secded_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [secded_pkg::WORD_W-1:0]    read_data;
  logic [secded_pkg::STATUS_W-1:0]  status;
  logic [secded_pkg::POS_W-1:0]     syndrome;
  logic [secded_pkg::POS_W-1:0]     err_pos;

  modport source (output valid, read_data, status, syndrome, err_pos, input ready);
  modport sink (input valid, read_data, status, syndrome, err_pos, output ready);
endinterface

// ===== rtl/secded_ctrl.sv =====
module secded_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  secded_pkg::ctrl_stat_t stat,
  output secded_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DECODE,
    S_UPDATE
  } state_t;

  state_t state;
  logic   rsp_full;
  logic   req_fire;
  logic   rsp_take;
  logic   upd_go;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_valid = rsp_full;
  assign rsp_take  = rsp_full && rsp_ready;
  // the output register must be free (or emptied this cycle) to take a new result
  assign upd_go    = (state == S_UPDATE) && (!rsp_full || rsp_ready);

  always_comb begin
    cmd          = '0;
    cmd.clear_en = (state == S_CLEAR);
    cmd.load     = req_fire;
    cmd.rd_en    = (state == S_READ);
    cmd.dec_en   = (state == S_DECODE);
    cmd.upd_en   = upd_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      rsp_full <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_fire) state <= S_READ;
        end
        S_READ:   state <= S_DECODE;
        S_DECODE: state <= S_UPDATE;
        S_UPDATE: begin
          if (upd_go) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase

      if (upd_go) begin
        rsp_full <= 1'b1;
      end else if (rsp_take) begin
        rsp_full <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> state == S_CLEAR)
    else $error("state after reset is not the clearing pass");
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == S_READ)
    else $error("accepted word did not start a memory read");
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_full) |-> $past(state == S_UPDATE))
    else $error("result raised outside the update step");
  a_update_done: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> rsp_full && state == S_IDLE)
    else $error("update did not load the output register");
`endif

endmodule

// ===== rtl/secded_dp.sv =====
module secded_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 16384
) (
  input  logic                               clk,
  input  logic                               rst,
  input  secded_pkg::ctrl_cmd_t              cmd,
  output secded_pkg::ctrl_stat_t             stat,
  input  logic [1:0]                         operation,
  input  logic [secded_pkg::ADDR_W-1:0]      address,
  input  logic [secded_pkg::WORD_W-1:0]      write_data,
  input  logic [secded_pkg::POS_W-1:0]       bit_position,
  input  logic [secded_pkg::POS_W-1:0]       flip_span,
  output logic [secded_pkg::WORD_W-1:0]      read_data,
  output logic [secded_pkg::STATUS_W-1:0]    status,
  output logic [secded_pkg::POS_W-1:0]       syndrome,
  output logic [secded_pkg::POS_W-1:0]       err_pos
);

  localparam int PAR_BITS  = (DATA_WIDTH <= 11) ? 4 : ((DATA_WIDTH <= 26) ? 5 : 6);
  localparam int TOTAL     = DATA_WIDTH + PAR_BITS + 1;
  localparam int MEM_DEPTH = (DEPTH < secded_pkg::ADDR_SPACE) ? DEPTH : secded_pkg::ADDR_SPACE;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [secded_pkg::ADDR_W:0] ADDR_LIMIT =
    (DEPTH > secded_pkg::ADDR_SPACE) ? (secded_pkg::ADDR_W + 1)'(secded_pkg::ADDR_SPACE)
                                     : (secded_pkg::ADDR_W + 1)'(DEPTH);
  localparam logic [5:0] TOTAL_POS = 6'(TOTAL);

  function automatic logic [5:0] syndrome_of(input logic [TOTAL-1:0] cw);
    logic [5:0] s;
    s = '0;
    for (int p = 1; p < TOTAL; p++) begin
      if (cw[p-1]) s = s ^ 6'(p);
    end
    return s;
  endfunction

  function automatic logic [TOTAL-1:0] encode(input logic [DATA_WIDTH-1:0] d);
    logic [TOTAL-1:0] cw;
    logic [5:0]       s;
    int               k;
    cw = '0;
    k  = 0;
    for (int p = 1; p < TOTAL; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[p-1] = d[k];
        k = k + 1;
      end
    end
    s = syndrome_of(cw);
    for (int i = 0; i < PAR_BITS; i++) begin
      cw[(1 << i) - 1] = s[i];
    end
    cw[TOTAL-1] = ^cw[TOTAL-2:0];
    return cw;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] extract(input logic [TOTAL-1:0] cw);
    logic [DATA_WIDTH-1:0] d;
    int                    k;
    d = '0;
    k = 0;
    for (int p = 1; p < TOTAL; p++) begin
      if ((p & (p - 1)) != 0) begin
        d[k] = cw[p-1];
        k = k + 1;
      end
    end
    return d;
  endfunction

  logic [TOTAL-1:0]      cw_mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] sh_mem [MEM_DEPTH];

  // item registers
  secded_pkg::op_t               op;
  logic [AW-1:0]                 idx;
  logic [DATA_WIDTH-1:0]         wdata;
  logic [secded_pkg::POS_W-1:0]  bpos;
  logic [secded_pkg::POS_W-1:0]  blen;
  logic                          addr_bad;

  // read and decode registers
  logic [TOTAL-1:0]      cw_rd;
  logic [DATA_WIDTH-1:0] sh_rd;
  logic [5:0]            syn;
  logic                  odd;
  logic [TOTAL-1:0]      syn_mask;
  logic [TOTAL-1:0]      flip_mask;
  logic                  flip_bad;

  logic [AW-1:0]         clr_cnt;

  // output register
  logic [secded_pkg::WORD_W-1:0]   rdata_out;
  secded_pkg::status_t             status_out;
  logic [secded_pkg::POS_W-1:0]    syn_out;
  logic [secded_pkg::POS_W-1:0]    epos_out;

  // decode-stage combinational
  logic [5:0]            syn_c;
  logic [TOTAL-1:0]      syn_mask_c;
  logic [TOTAL-1:0]      flip_mask_c;
  logic [6:0]            burst_end;
  logic                  flip_bad_c;

  // update-stage combinational
  logic [TOTAL-1:0]      corr;
  logic                  fixed;
  logic [DATA_WIDTH-1:0] rd_c;
  secded_pkg::status_t   st_c;
  logic [5:0]            syn_o_c;
  logic [5:0]            epos_c;
  logic                  cw_we;
  logic                  sh_we;
  logic [TOTAL-1:0]      w_cw;

  logic                  mem_cw_we;
  logic                  mem_sh_we;
  logic [AW-1:0]         w_idx;
  logic [TOTAL-1:0]      w_cw_mem;
  logic [DATA_WIDTH-1:0] w_sh_mem;

  assign stat.clear_last = (clr_cnt == AW'(MEM_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en && !stat.clear_last) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= secded_pkg::op_t'(operation);
      idx      <= address[AW-1:0];
      wdata    <= DATA_WIDTH'(write_data);
      bpos     <= bit_position;
      blen     <= flip_span;
      addr_bad <= ({1'b0, address} >= ADDR_LIMIT);
    end
  end

  always_comb begin
    syn_c     = syndrome_of(cw_rd);
    burst_end = {1'b0, bpos} + {1'b0, blen};
    for (int p = 1; p <= TOTAL; p++) begin
      syn_mask_c[p-1] = (p < TOTAL) && (syn_c == 6'(p));
      if (op == secded_pkg::OP_FLIP) begin
        flip_mask_c[p-1] = (bpos == 6'(p));
      end else begin
        flip_mask_c[p-1] = (7'(p) >= {1'b0, bpos}) && (7'(p) < burst_end);
      end
    end
    if (op == secded_pkg::OP_FLIP) begin
      flip_bad_c = (bpos == '0) || (bpos > TOTAL_POS);
    end else begin
      flip_bad_c = (blen == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_en) begin
      syn       <= syn_c;
      odd       <= ^cw_rd;
      syn_mask  <= syn_mask_c;
      flip_mask <= flip_mask_c;
      flip_bad  <= flip_bad_c;
    end
  end

  always_comb begin
    corr    = '0;
    fixed   = 1'b0;
    rd_c    = '0;
    st_c    = secded_pkg::ST_CLEAN;
    syn_o_c = '0;
    epos_c  = '0;
    cw_we   = 1'b0;
    sh_we   = 1'b0;
    w_cw    = cw_rd;
    if (addr_bad) begin
      st_c = secded_pkg::ST_REJECTED;
    end else begin
      case (op)
        secded_pkg::OP_WRITE: begin
          cw_we = 1'b1;
          sh_we = 1'b1;
          w_cw  = encode(wdata);
        end
        secded_pkg::OP_READ: begin
          syn_o_c = syn;
          if (syn == '0) begin
            if (odd) begin
              corr[TOTAL-1] = 1'b1;
              fixed         = 1'b1;
              st_c          = secded_pkg::ST_CORRECTED;
              epos_c        = TOTAL_POS;
            end
          end else if (odd) begin
            // a syndrome past the Hamming positions reports but corrects nothing
            st_c   = secded_pkg::ST_CORRECTED;
            epos_c = syn;
            corr   = syn_mask;
            fixed  = (syn < TOTAL_POS);
          end else begin
            st_c = secded_pkg::ST_UNCORRECTABLE;
          end
          rd_c = extract(cw_rd ^ corr);
          if (fixed) begin
            cw_we = 1'b1;
            w_cw  = encode(rd_c);
          end
          if (st_c == secded_pkg::ST_CLEAN && rd_c != sh_rd) begin
            st_c = secded_pkg::ST_UNDETECTED;
          end
        end
        secded_pkg::OP_FLIP, secded_pkg::OP_BURST: begin
          if (flip_bad) begin
            st_c = secded_pkg::ST_REJECTED;
          end else begin
            cw_we = 1'b1;
            w_cw  = cw_rd ^ flip_mask;
          end
        end
        default: st_c = secded_pkg::ST_REJECTED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      rdata_out  <= secded_pkg::WORD_W'(rd_c);
      status_out <= st_c;
      syn_out    <= syn_o_c;
      epos_out   <= epos_c;
    end
  end

  // clearing pass and updates share the single write port
  always_comb begin
    if (cmd.clear_en) begin
      mem_cw_we = 1'b1;
      mem_sh_we = 1'b1;
      w_idx     = clr_cnt;
      w_cw_mem  = '0;
      w_sh_mem  = '0;
    end else begin
      mem_cw_we = cmd.upd_en && cw_we;
      mem_sh_we = cmd.upd_en && sh_we;
      w_idx     = idx;
      w_cw_mem  = w_cw;
      w_sh_mem  = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_cw_we) cw_mem[w_idx] <= w_cw_mem;
    if (cmd.rd_en) cw_rd <= cw_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (mem_sh_we) sh_mem[w_idx] <= w_sh_mem;
    if (cmd.rd_en) sh_rd <= sh_mem[idx];
  end

  assign read_data = rdata_out;
  assign status    = status_out;
  assign syndrome  = syn_out;
  assign err_pos   = epos_out;

endmodule

// ===== rtl/secded_ecc_memory_core.sv =====
// SECDED-protected word memory with fault injection.
// Requests arrive on req (valid/ready); each accepted word carries an
// operation (write, read, flip one bit, flip a burst), an address and the
// operation's arguments. Every accepted word yields exactly one result word
// on rsp: read data, status, syndrome and error position.
// Each word is a read-modify-write of the codeword and shadow memories
// through one read port and one write port: memory read, decode, update.
// A result reaches the output register through the read, decode and update
// steps, and the next request is taken only after the update step, so a word
// is not accepted until the previous one is through that sequence.
// A new request is accepted while an earlier result still waits on rsp;
// if rsp stays stalled, the update step holds until the output register
// frees, and req.ready stays low meanwhile.
// After rst (synchronous, active high) both memories are cleared to zero,
// one entry per cycle, with req.ready low until the pass ends.
// Addresses at or above DEPTH are rejected and change nothing.
module secded_ecc_memory_core #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 16384
) (
  input logic           clk,
  input logic           rst,
  secded_req_if.sink    req,
  secded_rsp_if.source  rsp
);

  secded_pkg::ctrl_cmd_t  cmd;
  secded_pkg::ctrl_stat_t stat;

  secded_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  secded_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (req.operation),
    .address        (req.address),
    .write_data     (req.write_data),
    .bit_position   (req.bit_position),
    .flip_span      (req.flip_span),
    .read_data      (rsp.read_data),
    .status         (rsp.status),
    .syndrome       (rsp.syndrome),
    .err_pos        (rsp.err_pos)
  );

endmodule

// ===== test/secded_ecc_memory_core_checker.sv =====
module secded_ecc_memory_core_checker (
  input  logic  clk,
  input  logic  rst,
  secded_req_if req,
  secded_rsp_if rsp,
  output int    mismatches,
  output int    pending,
  output int    checked,
  output int    status_tally [5]
);
  import secded_pkg::*;

  localparam int CHECK_W = 6;
  localparam int CODE_W  = WORD_W + CHECK_W + 1;

  // index p-1 holds codeword position p
  typedef logic [CODE_W-1:0] codeword_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    status_t           status;
    logic [POS_W-1:0]  syndrome;
    logic [POS_W-1:0]  err_pos;
  } rsp_word_t;

  codeword_t         codeword_mem [ADDR_SPACE];
  logic [WORD_W-1:0] shadow_mem [ADDR_SPACE];
  rsp_word_t         awaited_rsp [$];

  function automatic logic [POS_W-1:0] hamming_syndrome(codeword_t cw);
    logic [POS_W-1:0] s;
    s = '0;
    for (int p = 1; p < CODE_W; p++)
      if (cw[p-1]) s ^= POS_W'(p);
    return s;
  endfunction

  function automatic codeword_t hamming_encode(logic [WORD_W-1:0] d);
    codeword_t        cw;
    int               k;
    logic [POS_W-1:0] s;
    cw = '0;
    k = 0;
    for (int p = 1; p < CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[p-1] = d[k];
        k++;
      end
    end
    s = hamming_syndrome(cw);
    for (int i = 0; i < CHECK_W; i++)
      if (s[i]) cw[(1 << i) - 1] = 1'b1;
    cw[CODE_W-1] = ^cw[CODE_W-2:0];
    return cw;
  endfunction

  function automatic logic [WORD_W-1:0] hamming_data(codeword_t cw);
    logic [WORD_W-1:0] d;
    int                k;
    d = '0;
    k = 0;
    for (int p = 1; p < CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        d[k] = cw[p-1];
        k++;
      end
    end
    return d;
  endfunction

  // apply one request to the mirrored stores and return the result word it yields
  function automatic rsp_word_t memory_access_result(op_t op, logic [ADDR_W-1:0] a,
                                                     logic [WORD_W-1:0] wdata,
                                                     logic [POS_W-1:0] bit_pos,
                                                     logic [POS_W-1:0] burst_len);
    rsp_word_t        r;
    codeword_t        cw;
    logic             odd;
    logic             fixed;
    logic [POS_W-1:0] syn;
    int               b;
    r = '0;
    r.status = ST_CLEAN;
    fixed = 1'b0;
    if (int'(a) >= ADDR_SPACE) begin
      r.status = ST_REJECTED;
    end else begin
      case (op)
        OP_WRITE: begin
          shadow_mem[a] = wdata;
          codeword_mem[a] = hamming_encode(wdata);
        end
        OP_READ: begin
          cw = codeword_mem[a];
          odd = ^cw;
          syn = hamming_syndrome(cw);
          r.syndrome = syn;
          if (syn == 0 && !odd) begin
            r.status = ST_CLEAN;
          end else if (syn == 0) begin
            r.status = ST_CORRECTED;
            r.err_pos = POS_W'(CODE_W);
            cw[CODE_W-1] = ~cw[CODE_W-1];
            fixed = 1'b1;
          end else if (odd) begin
            r.status = ST_CORRECTED;
            r.err_pos = syn;
            // a syndrome pointing past the Hamming positions flips nothing
            if (int'(syn) < CODE_W) begin
              cw[int'(syn) - 1] = ~cw[int'(syn) - 1];
              fixed = 1'b1;
            end
          end else begin
            r.status = ST_UNCORRECTABLE;
          end
          r.read_data = hamming_data(cw);
          if (fixed) codeword_mem[a] = hamming_encode(r.read_data);
          if (r.status == ST_CLEAN && r.read_data != shadow_mem[a]) r.status = ST_UNDETECTED;
        end
        OP_FLIP: begin
          if (bit_pos == 0 || int'(bit_pos) > CODE_W) r.status = ST_REJECTED;
          else codeword_mem[a][int'(bit_pos) - 1] = ~codeword_mem[a][int'(bit_pos) - 1];
        end
        default: begin
          if (burst_len == 0) begin
            r.status = ST_REJECTED;
          end else begin
            for (int i = 0; i < int'(burst_len); i++) begin
              b = int'(bit_pos) + i;
              if (b >= 1 && b <= CODE_W) codeword_mem[a][b-1] = ~codeword_mem[a][b-1];
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    logic      bad;
    if (rst) begin
      foreach (codeword_mem[i]) codeword_mem[i] = '0;
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      awaited_rsp.delete();
      mismatches = 0;
      checked = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.read_data = rsp.read_data;
        got.status = status_t'(rsp.status);
        got.syndrome = rsp.syndrome;
        got.err_pos = rsp.err_pos;
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected result word: data %h status %0d syndrome %0d position %0d",
                   $time, got.read_data, got.status, got.syndrome, got.err_pos);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          checked++;
          status_tally[want.status]++;
          bad = 1'b0;
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h got %h", $time, want.read_data, got.read_data);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.syndrome !== want.syndrome) begin
            $display("%0t: syndrome expected %0d got %0d", $time, want.syndrome, got.syndrome);
            bad = 1'b1;
          end
          if (got.err_pos !== want.err_pos) begin
            $display("%0t: error position expected %0d got %0d", $time,
                     want.err_pos, got.err_pos);
            bad = 1'b1;
          end
          if (bad) mismatches++;
        end
      end
      if (req.valid && req.ready)
        awaited_rsp.insert(awaited_rsp.size(),
                           memory_access_result(op_t'(req.operation), req.address,
                                                req.write_data, req.bit_position,
                                                req.flip_span));
    end
    pending = awaited_rsp.size();
  end

endmodule

// ===== test/secded_ecc_memory_core_tb.sv =====
module secded_ecc_memory_core_tb;
  import secded_pkg::*;

  localparam int CODE_BITS   = WORD_W + 7;
  localparam int WORD_TARGET = 1550;
  // covers the clearing pass after reset plus the longest stalls, several times over
  localparam int STALL_LIMIT = 50000;

  logic clk;
  logic rst;

  secded_req_if req();
  secded_rsp_if rsp();

  int mismatches;
  int pending;
  int checked;
  int status_tally [5];
  int sent = 0;
  int stall_cycles = 0;

  logic [ADDR_W-1:0] hot_addr [16];

  secded_ecc_memory_core uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  secded_ecc_memory_core_checker ecc_check (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .pending(pending),
    .checked(checked),
    .status_tally(status_tally)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
      $display("secded_ecc_memory_core_tb: errors");
      $finish;
    end
  end

  // result side back-pressure, with calm stretches where ready stays high
  initial begin
    int hold;
    int r;
    int ticks;
    hold = 0;
    ticks = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      ticks++;
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if ((ticks / 400) % 4 == 1) begin
        rsp.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp.ready <= 1'b1;
        end else begin
          rsp.ready <= 1'b0;
          hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if ((sent / 120) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high between back-to-back words; drop it only for a gap
  task automatic send_word(op_t op, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] wdata,
                           logic [POS_W-1:0] bit_pos, logic [POS_W-1:0] burst_len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.address <= a;
    req.write_data <= wdata;
    req.bit_position <= bit_pos;
    req.flip_span <= burst_len;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_word(logic [ADDR_W-1:0] a, logic [WORD_W-1:0] d);
    send_word(OP_WRITE, a, d, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic read_word(logic [ADDR_W-1:0] a);
    send_word(OP_READ, a, $urandom, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic flip_bit(logic [ADDR_W-1:0] a, logic [POS_W-1:0] pos);
    send_word(OP_FLIP, a, $urandom, pos, POS_W'($urandom));
  endtask

  task automatic burst_flip(logic [ADDR_W-1:0] a, logic [POS_W-1:0] pos,
                            logic [POS_W-1:0] len);
    send_word(OP_BURST, a, $urandom, pos, len);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int                r;
    int                kind;
    int                p;
    logic [ADDR_W-1:0] addr;

    rst <= 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_WRITE;
    req.address <= '0;
    req.write_data <= '0;
    req.bit_position <= '0;
    req.flip_span <= '0;
    hot_addr[0] = '0;
    hot_addr[1] = ADDR_W'(ADDR_SPACE - 1);
    for (int i = 2; i < 16; i++) hot_addr[i] = ADDR_W'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, each operation, rejected arguments
    read_word(14'd0);
    write_word(14'd0, 32'hFFFF_FFFF);
    read_word(14'd0);
    write_word(ADDR_W'(ADDR_SPACE - 1), 32'h0);
    read_word(ADDR_W'(ADDR_SPACE - 1));
    write_word(14'd1, 32'hA5A5_A5A5);
    flip_bit(14'd1, 6'd1);
    read_word(14'd1);
    flip_bit(14'd1, POS_W'(CODE_BITS));
    read_word(14'd1);
    flip_bit(14'd1, 6'd38);
    flip_bit(14'd1, 6'd5);
    read_word(14'd1);
    flip_bit(14'd1, 6'd0);
    flip_bit(14'd1, POS_W'(CODE_BITS + 1));
    burst_flip(14'd1, 6'd63, 6'd0);
    // burst running off the top of the codeword, maximum length
    write_word(14'd4, 32'h1234_5678);
    burst_flip(14'd4, 6'd37, 6'd63);
    read_word(14'd4);
    // four flips forming a valid codeword: reads clean but differs from the shadow
    burst_flip(14'd2, 6'd1, 6'd3);
    flip_bit(14'd2, POS_W'(CODE_BITS));
    read_word(14'd2);
    // odd parity with a syndrome past the last position
    flip_bit(14'd3, 6'd8);
    flip_bit(14'd3, 6'd32);
    flip_bit(14'd3, POS_W'(CODE_BITS));
    read_word(14'd3);
    drain();

    while (sent < WORD_TARGET) begin
      addr = hot_addr[4'($urandom_range(0, 15))];
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_word(op_t'($urandom_range(0, 3)), ADDR_W'($urandom), $urandom,
                  POS_W'($urandom), POS_W'($urandom));
      end else begin
        if ($urandom_range(0, 9) < 8) begin
          r = $urandom_range(0, 9);
          write_word(addr, (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom);
        end
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          // leave the word intact
        end else if (kind < 40) begin
          flip_bit(addr, POS_W'($urandom_range(1, CODE_BITS)));
        end else if (kind < 55) begin
          repeat (2) flip_bit(addr, POS_W'($urandom_range(1, CODE_BITS)));
        end else if (kind < 70) begin
          burst_flip(addr, POS_W'($urandom_range(0, CODE_BITS + 1)),
                     POS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 63)
                                                        : $urandom_range(1, 6)));
        end else if (kind < 80) begin
          // flip the codeword of a one-hot data word so the error goes unseen
          p = $urandom_range(3, CODE_BITS - 1);
          while ((p & (p - 1)) == 0) p = $urandom_range(3, CODE_BITS - 1);
          flip_bit(addr, POS_W'(p));
          for (int i = 0; i < 6; i++)
            if (p[i]) flip_bit(addr, POS_W'(1 << i));
          if ($countones(p) % 2 == 0) flip_bit(addr, POS_W'(CODE_BITS));
        end else if (kind < 90) begin
          repeat (3) flip_bit(addr, POS_W'($urandom_range(1, CODE_BITS)));
        end else begin
          case ($urandom_range(0, 2))
            0: flip_bit(addr, 6'd0);
            1: flip_bit(addr, POS_W'($urandom_range(CODE_BITS + 1, 63)));
            default: burst_flip(addr, POS_W'($urandom), 6'd0);
          endcase
        end
        if ($urandom_range(0, 19) != 0) read_word(addr);
        if ($urandom_range(0, 9) < 4) read_word(addr);
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("%0d words sent, %0d results checked over writes, reads, flips and bursts",
             sent, checked);
    $display("status seen: clean %0d, corrected %0d, uncorrectable %0d, undetected %0d,",
             status_tally[ST_CLEAN], status_tally[ST_CORRECTED],
             status_tally[ST_UNCORRECTABLE], status_tally[ST_UNDETECTED]);
    $display("  rejected %0d", status_tally[ST_REJECTED]);
    if (mismatches == 0) begin
      $display("secded_ecc_memory_core_tb: clean");
    end else begin
      $display("secded_ecc_memory_core_tb: errors");
    end
    $finish;
  end

endmodule
